### hdl/upd_pkg.sv
package upd_pkg;

  localparam int unsigned CapW   = 17;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CapW-1:0] CapReset = CapW'(256);

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } phase_e;

  // One queue entry holds every result that a single input beat causes.
  typedef struct packed {
    logic [1:0]      nres;   // results in this entry, 1 to 3
    logic            datav;  // clear for the empty end-of-string result
    logic            last;
    logic            trunc;
    logic [2:0][7:0] data;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

### hdl/upd_front.sv
module upd_front import upd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            q_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output entry_t          push_entry_o
);

  logic [CapW-1:0] cap_q;
  phase_e          phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic [CapW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;

  logic            accept;
  logic [2:0][7:0] att;
  logic [1:0]      natt;
  logic [CapW-1:0] limit;
  logic [CapW-1:0] room;
  logic [1:0]      nok;
  logic            drop_now;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Collect the bytes this beat tries to emit, in order.
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    att     = '0;
    natt    = 2'd0;
    case (phase_q)
      PH_PCT: begin
        if (is_hex(in_byte_i)) begin
          phase_d = PH_DIGIT;
          held_d  = in_byte_i;
        end else begin
          phase_d = PH_IDLE;
          att[natt] = CharPct;
          natt = natt + 2'd1;
          if (in_byte_i == CharPct) begin
            phase_d = PH_PCT;
          end else begin
            att[natt] = (in_byte_i == CharPlus) ? CharSpace : in_byte_i;
            natt = natt + 2'd1;
          end
        end
      end
      PH_DIGIT: begin
        phase_d = PH_IDLE;
        if (is_hex(in_byte_i)) begin
          att[natt] = {hex_nib(held_q), hex_nib(in_byte_i)};
          natt = natt + 2'd1;
        end else begin
          att[natt] = CharPct;
          natt = natt + 2'd1;
          att[natt] = held_q;
          natt = natt + 2'd1;
          if (in_byte_i == CharPct) begin
            phase_d = PH_PCT;
          end else begin
            att[natt] = (in_byte_i == CharPlus) ? CharSpace : in_byte_i;
            natt = natt + 2'd1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (in_byte_i == CharPct) begin
          phase_d = PH_PCT;
        end else begin
          att[natt] = (in_byte_i == CharPlus) ? CharSpace : in_byte_i;
          natt = natt + 2'd1;
        end
      end
    endcase
    // An escape left open at the end of the string is flushed literally.
    if (in_last_i) begin
      if (phase_d == PH_PCT) begin
        att[natt] = CharPct;
        natt = natt + 2'd1;
      end else if (phase_d == PH_DIGIT) begin
        att[natt] = CharPct;
        natt = natt + 2'd1;
        att[natt] = held_d;
        natt = natt + 2'd1;
      end
    end
  end

  // Emissions past the limit are dropped; once one fails, all later ones do.
  always_comb begin
    limit = (cap_q == '0) ? '0 : cap_q - CapW'(1);
    room  = (count_q < limit) ? limit - count_q : '0;
    if (room < CapW'(natt)) begin
      nok = room[1:0];
    end else begin
      nok = natt;
    end
    drop_now  = (nok != natt);
    dropped_d = dropped_q || drop_now;
    count_d   = count_q + CapW'(nok);
  end

  always_comb begin
    push_entry_o.data  = att;
    push_entry_o.datav = (nok != 2'd0);
    push_entry_o.nres  = (nok == 2'd0) ? 2'd1 : nok;
    push_entry_o.last  = in_last_i;
    push_entry_o.trunc = dropped_d;
    push_o = accept && ((nok != 2'd0) || in_last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CapReset;
      phase_q   <= PH_IDLE;
      held_q    <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (in_last_i) begin
          phase_q   <= PH_IDLE;
          held_q    <= '0;
          count_q   <= '0;
          dropped_q <= 1'b0;
        end else begin
          phase_q   <= phase_d;
          held_q    <= held_d;
          count_q   <= count_d;
          dropped_q <= dropped_d;
        end
      end
    end
  end

endmodule

### hdl/upd_queue.sv
module upd_queue import upd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

### hdl/upd_back.sv
module upd_back import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  entry_t     head_i,
  input  logic       res_stall_i,
  output logic       pop_o,
  output logic       res_valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       out_last_o,
  output logic       out_truncated_o
);

  logic [1:0] idx_q;
  logic       final_res;
  logic       beat;

  assign final_res   = (idx_q == head_i.nres - 2'd1);
  assign res_valid_o = !empty_i;
  assign beat        = res_valid_o && !res_stall_i;
  assign pop_o       = beat && final_res;

  assign out_byte_o      = head_i.datav ? head_i.data[idx_q] : 8'h00;
  assign out_valid_o     = head_i.datav;
  assign out_last_o      = head_i.last && final_res;
  assign out_truncated_o = head_i.trunc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (beat) begin
      idx_q <= final_res ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

### hdl/url_percent_decoder_core.sv
// URL percent decoder.
// Input channel: in_valid_i / in_stall_o carry one encoded byte per beat with
// in_last_i on the final byte of a string. Result channel: res_valid_o /
// res_stall_i carry one decoded result per beat (byte, data flag, last flag,
// truncation flag). cfg_we_i writes the destination capacity; the user
// must do so only while idle, as the block itself does not enforce it. A
// front stage decodes each input byte in the cycle it is accepted and pushes
// all of its results as one entry into a two-entry queue, where they are
// registered; the back stage shows the queue head and sends one result per
// cycle while the receiver does not stall. Input takes one byte per cycle
// under the same condition when each byte yields at most one result; two or
// three results of a byte go out one by one through the single result port.
// Reset clears the escape state, the counters and the queue and sets the
// capacity to 256. While the receiver stalls, the shown result holds and
// the queue fills; input stalls once both entries are occupied.
module url_percent_decoder_core import upd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_valid_o,
  output logic            out_last_o,
  output logic            out_truncated_o
);

  logic   q_full, q_empty, push, pop;
  entry_t push_entry, head;

  upd_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_byte_i,
    .in_last_i,
    .q_full_i     (q_full),
    .in_stall_o,
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  upd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (q_full),
    .empty_o      (q_empty),
    .head_o       (head)
  );

  upd_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i     (q_empty),
    .head_i      (head),
    .res_stall_i,
    .pop_o       (pop),
    .res_valid_o,
    .out_byte_o,
    .out_valid_o,
    .out_last_o,
    .out_truncated_o
  );

endmodule

### hdl/upd_checker.sv
module upd_checker import upd_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            res_valid_o,
  input logic            res_stall_i,
  input logic [7:0]      out_byte_o,
  input logic            out_valid_o,
  input logic            out_last_o,
  input logic            out_truncated_o
);

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(out_byte_o) &&
      $stable(out_valid_o) && $stable(out_last_o) && $stable(out_truncated_o))
    else $error("stalled result changed");

  // A result without data only closes a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> out_last_o && (out_byte_o == 8'h00))
    else $error("empty result that does not end a string");

  // Without an output beat the queue cannot drain, so input stays stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !(res_valid_o && !res_stall_i) |=> in_stall_o)
    else $error("input stall released without a result beat");

  // Input is stalled only while results are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> res_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind url_percent_decoder_core upd_checker u_upd_checker (
  .clk_i,
  .rst_ni,
  .in_stall_o,
  .res_valid_o,
  .res_stall_i,
  .out_byte_o,
  .out_valid_o,
  .out_last_o,
  .out_truncated_o
);
